### hw/rtl/asm_pkg.sv
// Shared types, widths, register indexes and helpers for the accelerometer model.
// Used by every module of the block; depends on nothing.
package asm_pkg;

   localparam int WINDOW_DEFAULT   = 16;
   localparam int NUM_AXES_DEFAULT = 3;
   localparam int QDEPTH           = 2;

   localparam int AW   = 38;
   localparam int BW   = 27;
   localparam int PW   = AW + BW;
   localparam int ACCW = 68;
   localparam int ROTW = BW;

   localparam logic [2:0] MAC_NOP   = 3'd0;
   localparam logic [2:0] MAC_LOAD  = 3'd1;
   localparam logic [2:0] MAC_ADD   = 3'd2;
   localparam logic [2:0] MAC_SUB   = 3'd3;
   localparam logic [2:0] MAC_ADDSH = 3'd4;

   localparam logic [2:0] REG_INV_TIME_STEP = 3'd0;
   localparam logic [2:0] REG_GRAVITY       = 3'd1;
   localparam logic [2:0] REG_MAX_READING   = 3'd2;
   localparam logic [2:0] REG_WINDOW_LEN    = 3'd3;
   localparam logic [2:0] REG_MOUNT_OFFSET  = 3'd4;
   localparam logic [2:0] REG_AXIS_ONE      = 3'd5;
   localparam logic [2:0] REG_AXIS_TWO      = 3'd6;
   localparam logic [2:0] REG_AXIS_THREE    = 3'd7;

   localparam logic [31:0] RST_INV_TIME_STEP = 32'd6553600;
   localparam logic [30:0] RST_MAX_READING   = 31'd771490;
   localparam logic [4:0]  RST_WINDOW_LEN    = 5'd1;
   localparam logic [47:0] RST_AXIS_ONE      = 48'h4000_0000_0000;
   localparam logic [47:0] RST_AXIS_TWO      = 48'h0000_0000_4000;
   localparam logic [47:0] RST_AXIS_THREE    = 48'h0000_C000_0000;

   typedef struct packed {
      logic        restart;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [15:0] quat_w;
      logic [15:0] quat_x;
      logic [15:0] quat_y;
      logic [15:0] quat_z;
   } item_type;

   typedef struct packed {
      logic [31:0] inv_time_step;
      logic [31:0] gravity;
      logic [30:0] max_reading;
      logic [4:0]  window_len;
      logic [62:0] mount_offset;
      logic [47:0] axis_one;
      logic [47:0] axis_two;
      logic [47:0] axis_three;
   } cfg_type;

   typedef struct packed {
      logic [2:0]    op;
      logic [AW-1:0] a;
      logic [BW-1:0] b;
   } mac_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] x);
      logic signed [ACCW-1:0] hi;
      logic signed [ACCW-1:0] lo;
      hi = ACCW'(32'sh7fff_ffff);
      lo = ACCW'(signed'(32'h8000_0000));
      if (x > hi) begin
         return 32'sh7fff_ffff;
      end else if (x < lo) begin
         return signed'(32'h8000_0000);
      end
      return 32'(x);
   endfunction

endpackage

### hw/rtl/asm_front.sv
// Front end: takes request transfers and holds them in a short queue for the back end.
// Depends on asm_pkg.
module asm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asm_pkg::item_type req_item,
   output logic              q_valid,
   output asm_pkg::item_type q_item,
   input  logic              q_pop
);
   import asm_pkg::*;

   localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QFW = $clog2(QDEPTH + 1);

   item_type       slot_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QFW-1:0] fill_ff;
   logic           accept;
   logic           take;

   assign req_stall = (32'(fill_ff) == QDEPTH);
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign take      = q_valid && q_pop;

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (accept && !take) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (take && !accept) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= QDEPTH)
      else $error("queue fill beyond depth");
   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill did not advance on transfer");

endmodule

### hw/rtl/asm_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulated in the following cycle.
// Depends on asm_pkg.
module asm_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  asm_pkg::mac_cmd_type            cmd,
   output logic signed [asm_pkg::ACCW-1:0] acc
);
   import asm_pkg::*;

   logic signed [AW-1:0]   a_s;
   logic signed [BW-1:0]   b_s;
   logic signed [PW-1:0]   prod_ff;
   logic [2:0]             op_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic signed [ACCW-1:0] prod_ext;

   assign a_s      = cmd.a;
   assign b_s      = cmd.b;
   assign prod_ext = ACCW'(prod_ff);
   assign acc      = acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PW'(a_s) * PW'(b_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_NOP;
      end else begin
         op_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      unique case (op_ff)
         MAC_LOAD:  acc_ff <= prod_ext;
         MAC_ADD:   acc_ff <= acc_ff + prod_ext;
         MAC_SUB:   acc_ff <= acc_ff - prod_ext;
         MAC_ADDSH: acc_ff <= acc_ff + {prod_ext[ACCW-17:0], 16'd0};
         default:   acc_ff <= acc_ff;
      endcase
   end

endmodule

### hw/rtl/asm_back.sv
// Back end: sequencer over the shared MAC for rotation, differencing and projection,
// then history ring, window sum and serial divide. Depends on asm_pkg and asm_mac.
module asm_back #(
   parameter int WINDOW   = asm_pkg::WINDOW_DEFAULT,
   parameter int NUM_AXES = asm_pkg::NUM_AXES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  asm_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  asm_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_reading_one,
   output logic signed [31:0] rsp_reading_two,
   output logic signed [31:0] rsp_reading_three,
   output logic               rsp_frozen
);
   import asm_pkg::*;

   localparam int HW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int LENW = $clog2(WINDOW + 1);
   localparam int SUMW = 32 + LENW;
   localparam int CNTW = (LENW > 5) ? LENW : 5;
   localparam int DCW  = $clog2(SUMW + 1);
   localparam int ROT_LAST = 23;
   localparam int DIFF_LAST = 11;
   localparam int DOT_LAST = 4;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ROT  = 4'd1;
   localparam logic [3:0] S_POS  = 4'd2;
   localparam logic [3:0] S_VEL  = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_DOT  = 4'd5;
   localparam logic [3:0] S_HOLD = 4'd6;
   localparam logic [3:0] S_SUM  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]              state_ff;
   logic [CNTW-1:0]         cnt_ff;
   item_type                item_ff;
   logic                    rot_off_ff;
   logic [1:0]              axis_ff;
   logic                    over_ff;
   logic signed [BW-1:0]    vec_ff [3];
   logic signed [ROTW-1:0]  rot_ff [3];
   logic signed [AW-1:0]    ww_ff;
   logic signed [AW-1:0]    d_ff;
   logic signed [AW-1:0]    c_ff [3];
   logic signed [31:0]      p_ff [3];
   logic signed [31:0]      prev_pos_ff [3];
   logic signed [31:0]      prev_vel_ff [3];
   logic signed [31:0]      vel_ff [3];
   logic signed [31:0]      accv_ff [3];
   logic signed [31:0]      raw_ff [3];
   logic signed [31:0]      held_ff [3];
   logic signed [31:0]      last_ff [3];
   logic signed [31:0]      out_ff [3];
   logic                    frozen_ff;
   logic [HW-1:0]           head_ff;
   logic [LENW-1:0]         count_ff;
   logic [LENW-1:0]         len_ff;
   logic [HW-1:0]           rd_ptr_ff;
   logic                    rd_vld_ff;
   logic signed [31:0]      rd_ff [3];
   logic signed [SUMW-1:0]  sum_ff [3];
   logic [SUMW-1:0]         mag_ff [3];
   logic [LENW-1:0]         rem_ff [3];
   logic                    neg_ff [3];
   logic [DCW-1:0]          dcnt_ff;

   logic signed [31:0]      hist_one [WINDOW];
   logic signed [31:0]      hist_two [WINDOW];
   logic signed [31:0]      hist_three [WINDOW];

   mac_cmd_type             cmd;
   logic signed [ACCW-1:0]  acc;
   logic signed [15:0]      qw, qx, qy, qz;
   logic signed [31:0]      p_c [3];
   logic [1:0]              idx;
   logic signed [32:0]      dv;
   logic signed [ACCW-1:0]  raw_c;
   logic signed [ACCW-1:0]  mag_c;
   logic                    hot_c;
   logic signed [31:0]      vals [3];
   logic [LENW-1:0]         len_c;
   logic [LENW:0]           cnt_inc;
   logic [LENW-1:0]         count_new;
   logic [HW-1:0]           head_next;
   logic signed [SUMW-1:0]  sum_next [3];
   logic signed [31:0]      v_one_tmp;
   logic [47:0]             next_axis;

   asm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .acc   (acc)
   );

   function automatic mac_cmd_type mk(input logic [2:0] op, input logic signed [AW-1:0] a,
                                      input logic signed [BW-1:0] b);
      mac_cmd_type c;
      c.op = op;
      c.a  = a;
      c.b  = b;
      return c;
   endfunction

   function automatic logic [47:0] pick_axis(input logic [1:0] k, input cfg_type c);
      unique case (k)
         2'd0:    return c.axis_one;
         2'd1:    return c.axis_two;
         default: return c.axis_three;
      endcase
   endfunction

   assign qw = item_ff.quat_w;
   assign qx = item_ff.quat_x;
   assign qy = item_ff.quat_y;
   assign qz = item_ff.quat_z;
   assign idx = cnt_ff[3:2];
   assign next_axis = pick_axis(axis_ff + 1'b1, cfg);

   always_comb begin
      p_c[0] = sat32(ACCW'(signed'(item_ff.pos_x)) + ACCW'(rot_ff[0]));
      p_c[1] = sat32(ACCW'(signed'(item_ff.pos_y)) + ACCW'(rot_ff[1]));
      p_c[2] = sat32(ACCW'(signed'(item_ff.pos_z)) + ACCW'(rot_ff[2]));
      if (state_ff == S_VEL) begin
         dv = 33'(p_ff[idx]) - 33'(prev_pos_ff[idx]);
      end else begin
         dv = 33'(vel_ff[idx]) - 33'(prev_vel_ff[idx]);
      end
      raw_c = (-acc) >>> 14;
      mag_c = raw_c[ACCW-1] ? -raw_c : raw_c;
      hot_c = ({30'd0, axis_ff} < NUM_AXES) && (mag_c > ACCW'(cfg.max_reading));
      v_one_tmp = sat32(acc >>> 16);
      for (int j = 0; j < 3; j++) begin
         vals[j] = over_ff ? held_ff[j] : raw_ff[j];
         sum_next[j] = sum_ff[j] + (rd_vld_ff ? SUMW'(rd_ff[j]) : SUMW'(0));
      end
      if (cfg.window_len == 5'd0) begin
         len_c = LENW'(1);
      end else if (32'(cfg.window_len) > WINDOW) begin
         len_c = LENW'(WINDOW);
      end else begin
         len_c = LENW'(cfg.window_len);
      end
      cnt_inc   = (LENW + 1)'(count_ff) + 1'b1;
      count_new = (cnt_inc > (LENW + 1)'(len_c)) ? len_c : LENW'(cnt_inc);
      head_next = (32'(head_ff) == WINDOW - 1) ? '0 : head_ff + 1'b1;
   end

   always_comb begin
      cmd = mk(MAC_NOP, '0, '0);
      case (state_ff)
         S_ROT: begin
            case (32'(cnt_ff))
               0:  cmd = mk(MAC_LOAD, AW'(qw), BW'(qw));
               1:  cmd = mk(MAC_SUB, AW'(qx), BW'(qx));
               2:  cmd = mk(MAC_SUB, AW'(qy), BW'(qy));
               3:  cmd = mk(MAC_SUB, AW'(qz), BW'(qz));
               4:  cmd = mk(MAC_LOAD, AW'(qx), vec_ff[0]);
               5:  cmd = mk(MAC_ADD, AW'(qy), vec_ff[1]);
               6:  cmd = mk(MAC_ADD, AW'(qz), vec_ff[2]);
               7:  cmd = mk(MAC_LOAD, AW'(qy), vec_ff[2]);
               8:  cmd = mk(MAC_SUB, AW'(qz), vec_ff[1]);
               9:  cmd = mk(MAC_LOAD, AW'(qz), vec_ff[0]);
               10: cmd = mk(MAC_SUB, AW'(qx), vec_ff[2]);
               11: cmd = mk(MAC_LOAD, AW'(qx), vec_ff[1]);
               12: cmd = mk(MAC_SUB, AW'(qy), vec_ff[0]);
               13: cmd = mk(MAC_LOAD, ww_ff, vec_ff[0]);
               14: cmd = mk(MAC_ADD, d_ff, BW'(qx) <<< 1);
               15: cmd = mk(MAC_ADD, c_ff[0], BW'(qw) <<< 1);
               16: cmd = mk(MAC_LOAD, ww_ff, vec_ff[1]);
               17: cmd = mk(MAC_ADD, d_ff, BW'(qy) <<< 1);
               18: cmd = mk(MAC_ADD, c_ff[1], BW'(qw) <<< 1);
               19: cmd = mk(MAC_LOAD, ww_ff, vec_ff[2]);
               20: cmd = mk(MAC_ADD, d_ff, BW'(qz) <<< 1);
               21: cmd = mk(MAC_ADD, c_ff[2], BW'(qw) <<< 1);
               default: cmd = mk(MAC_NOP, '0, '0);
            endcase
         end
         S_VEL, S_ACC: begin
            case (cnt_ff[1:0])
               2'd0: cmd = mk(MAC_LOAD, AW'(dv),
                              BW'(signed'({1'b0, cfg.inv_time_step[15:0]})));
               2'd1: cmd = mk(MAC_ADDSH, AW'(dv),
                              BW'(signed'({1'b0, cfg.inv_time_step[31:16]})));
               default: cmd = mk(MAC_NOP, '0, '0);
            endcase
         end
         S_DOT: begin
            case (32'(cnt_ff))
               0: cmd = mk(MAC_LOAD, AW'(accv_ff[0]), BW'(rot_ff[0]));
               1: cmd = mk(MAC_ADD, AW'(accv_ff[1]), BW'(rot_ff[1]));
               2: cmd = mk(MAC_ADD, AW'(accv_ff[2]), BW'(rot_ff[2]));
               default: cmd = mk(MAC_NOP, '0, '0);
            endcase
         end
         default: cmd = mk(MAC_NOP, '0, '0);
      endcase
   end

   assign q_pop             = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_reading_one   = out_ff[0];
   assign rsp_reading_two   = out_ff[1];
   assign rsp_reading_three = out_ff[2];
   assign rsp_frozen        = frozen_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_HOLD) begin
         hist_one[head_ff]   <= vals[0];
         hist_two[head_ff]   <= vals[1];
         hist_three[head_ff] <= vals[2];
      end
      rd_ff[0] <= hist_one[rd_ptr_ff];
      rd_ff[1] <= hist_two[rd_ptr_ff];
      rd_ff[2] <= hist_three[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         frozen_ff <= 1'b0;
         over_ff   <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            prev_pos_ff[j] <= '0;
            prev_vel_ff[j] <= '0;
            held_ff[j]     <= '0;
            last_ff[j]     <= '0;
            out_ff[j]      <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff    <= q_item;
                  rot_off_ff <= 1'b1;
                  axis_ff    <= 2'd0;
                  over_ff    <= 1'b0;
                  cnt_ff     <= '0;
                  for (int j = 0; j < 3; j++) begin
                     vec_ff[j] <= BW'(signed'(cfg.mount_offset[21*j +: 21]));
                  end
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               case (32'(cnt_ff))
                  5:  ww_ff <= AW'(acc);
                  8:  d_ff <= AW'(acc);
                  10: c_ff[0] <= AW'(acc);
                  12: c_ff[1] <= AW'(acc);
                  14: c_ff[2] <= AW'(acc);
                  17: rot_ff[0] <= ROTW'(acc >>> 28);
                  20: rot_ff[1] <= ROTW'(acc >>> 28);
                  23: rot_ff[2] <= ROTW'(acc >>> 28);
                  default: ;
               endcase
               if (32'(cnt_ff) == ROT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= rot_off_ff ? S_POS : S_DOT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_POS: begin
               p_ff <= p_c;
               if (item_ff.restart) begin
                  for (int j = 0; j < 3; j++) begin
                     prev_pos_ff[j] <= p_c[j];
                     prev_vel_ff[j] <= '0;
                     last_ff[j]     <= '0;
                     out_ff[j]      <= '0;
                  end
                  frozen_ff <= 1'b0;
                  count_ff  <= '0;
                  head_ff   <= '0;
                  state_ff  <= S_OUT;
               end else if (cfg.inv_time_step == '0) begin
                  out_ff    <= last_ff;
                  frozen_ff <= 1'b0;
                  state_ff  <= S_OUT;
               end else begin
                  cnt_ff   <= '0;
                  state_ff <= S_VEL;
               end
            end
            S_VEL: begin
               if (cnt_ff[1:0] == 2'd3) begin
                  vel_ff[idx] <= v_one_tmp;
               end
               if (32'(cnt_ff) == DIFF_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= S_ACC;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ACC: begin
               if (cnt_ff[1:0] == 2'd3) begin
                  if (idx == 2'd1) begin
                     accv_ff[idx] <= sat32(ACCW'(v_one_tmp) + ACCW'(signed'(cfg.gravity)));
                  end else begin
                     accv_ff[idx] <= v_one_tmp;
                  end
               end
               if (32'(cnt_ff) == DIFF_LAST) begin
                  cnt_ff     <= '0;
                  rot_off_ff <= 1'b0;
                  axis_ff    <= 2'd0;
                  for (int j = 0; j < 3; j++) begin
                     vec_ff[j] <= BW'(signed'(cfg.axis_one[16*j +: 16]));
                  end
                  state_ff <= S_ROT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DOT: begin
               if (32'(cnt_ff) == DOT_LAST) begin
                  raw_ff[axis_ff] <= sat32(raw_c);
                  if (hot_c) begin
                     over_ff <= 1'b1;
                  end
                  cnt_ff <= '0;
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_HOLD;
                  end else begin
                     axis_ff <= axis_ff + 1'b1;
                     for (int j = 0; j < 3; j++) begin
                        vec_ff[j] <= BW'(signed'(next_axis[16*j +: 16]));
                     end
                     state_ff <= S_ROT;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_HOLD: begin
               held_ff   <= vals;
               head_ff   <= head_next;
               count_ff  <= count_new;
               len_ff    <= len_c;
               rd_ptr_ff <= head_ff;
               rd_vld_ff <= 1'b0;
               cnt_ff    <= '0;
               for (int j = 0; j < 3; j++) begin
                  sum_ff[j] <= '0;
               end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff    <= sum_next;
               rd_vld_ff <= (cnt_ff < CNTW'(count_ff));
               if (cnt_ff < CNTW'(count_ff)) begin
                  cnt_ff    <= cnt_ff + 1'b1;
                  rd_ptr_ff <= (rd_ptr_ff == '0) ? HW'(WINDOW - 1) : rd_ptr_ff - 1'b1;
               end else begin
                  for (int j = 0; j < 3; j++) begin
                     neg_ff[j] <= sum_next[j][SUMW-1];
                     mag_ff[j] <= sum_next[j][SUMW-1] ? SUMW'(-sum_next[j])
                                                     : SUMW'(sum_next[j]);
                     rem_ff[j] <= '0;
                  end
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (32'(dcnt_ff) == SUMW) begin
                  for (int j = 0; j < 3; j++) begin
                     last_ff[j]     <= neg_ff[j] ? -signed'(32'(mag_ff[j]))
                                                 : signed'(32'(mag_ff[j]));
                     out_ff[j]      <= neg_ff[j] ? -signed'(32'(mag_ff[j]))
                                                 : signed'(32'(mag_ff[j]));
                     prev_pos_ff[j] <= p_ff[j];
                     prev_vel_ff[j] <= vel_ff[j];
                  end
                  frozen_ff <= over_ff;
                  state_ff  <= S_OUT;
               end else begin
                  for (int j = 0; j < 3; j++) begin
                     if ({rem_ff[j], mag_ff[j][SUMW-1]} >= {1'b0, len_ff}) begin
                        rem_ff[j] <= LENW'({rem_ff[j], mag_ff[j][SUMW-1]} - {1'b0, len_ff});
                        mag_ff[j] <= {mag_ff[j][SUMW-2:0], 1'b1};
                     end else begin
                        rem_ff[j] <= LENW'({rem_ff[j], mag_ff[j][SUMW-1]});
                        mag_ff[j] <= {mag_ff[j][SUMW-2:0], 1'b0};
                     end
                  end
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < WINDOW)
      else $error("history head out of range");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= WINDOW)
      else $error("history count beyond window");
   a_sum_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (count_ff != '0))
      else $error("window sum over empty history");

endmodule

### hw/rtl/accel_sensor_model.sv
// Top level of the accelerometer model: register file, front queue and back end.
// Depends on asm_pkg, asm_front and asm_back.
//
// One request transfer yields one response transfer. In a normal tick, with L the
// window length clamped to 1..WINDOW, four rotations, six differences and three
// projections go through the single 38x27 multiply-accumulate unit, the window sum
// reads up to L history entries, one per cycle, and the mean comes from a bit-serial
// divide of 32 + clog2(WINDOW+1) steps. Restart and zero step ticks end after the
// offset rotation. A two entry queue takes further requests while a tick is worked
// on, and the response register holds a result until it is taken. Write registers
// only while the block is idle.
module accel_sensor_model #(
   parameter int WINDOW   = asm_pkg::WINDOW_DEFAULT,
   parameter int NUM_AXES = asm_pkg::NUM_AXES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_reading_one,
   output logic signed [31:0] rsp_reading_two,
   output logic signed [31:0] rsp_reading_three,
   output logic               rsp_frozen,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import asm_pkg::*;

   cfg_type  cfg_ff;
   item_type req_item;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_time_step <= RST_INV_TIME_STEP;
         cfg_ff.gravity       <= '0;
         cfg_ff.max_reading   <= RST_MAX_READING;
         cfg_ff.window_len    <= RST_WINDOW_LEN;
         cfg_ff.mount_offset  <= '0;
         cfg_ff.axis_one      <= RST_AXIS_ONE;
         cfg_ff.axis_two      <= RST_AXIS_TWO;
         cfg_ff.axis_three    <= RST_AXIS_THREE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_INV_TIME_STEP: cfg_ff.inv_time_step <= csr_data[31:0];
            REG_GRAVITY:       cfg_ff.gravity       <= csr_data[31:0];
            REG_MAX_READING:   cfg_ff.max_reading   <= csr_data[30:0];
            REG_WINDOW_LEN:    cfg_ff.window_len    <= csr_data[4:0];
            REG_MOUNT_OFFSET:  cfg_ff.mount_offset  <= csr_data[62:0];
            REG_AXIS_ONE:      cfg_ff.axis_one      <= csr_data[47:0];
            REG_AXIS_TWO:      cfg_ff.axis_two      <= csr_data[47:0];
            REG_AXIS_THREE:    cfg_ff.axis_three    <= csr_data[47:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_item.restart = req_restart;
      req_item.pos_x   = req_pos_x;
      req_item.pos_y   = req_pos_y;
      req_item.pos_z   = req_pos_z;
      req_item.quat_w  = req_quat_w;
      req_item.quat_x  = req_quat_x;
      req_item.quat_y  = req_quat_y;
      req_item.quat_z  = req_quat_z;
   end

   asm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   asm_back #(
      .WINDOW   (WINDOW),
      .NUM_AXES (NUM_AXES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reading_one   (rsp_reading_one),
      .rsp_reading_two   (rsp_reading_two),
      .rsp_reading_three (rsp_reading_three),
      .rsp_frozen        (rsp_frozen)
   );

endmodule

### dv/accel_sensor_model_tb.sv
// Self-checking testbench for accel_sensor_model: random bursty requests, random
// response stalls and several register settings, checked against a built-in predictor.
// Depends on asm_pkg and the accel_sensor_model RTL.
module accel_sensor_model_tb;
   import asm_pkg::*;

   localparam int HIST_DEPTH = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef longint vec3_t[3];
   typedef longint quat_t[4];

   typedef struct {
      logic signed [31:0] one;
      logic signed [31:0] two;
      logic signed [31:0] three;
      logic               frozen;
   } reading_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_restart = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_reading_one, rsp_reading_two, rsp_reading_three;
   logic rsp_frozen;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = REG_INV_TIME_STEP;
   logic [63:0] csr_data = 0;

   accel_sensor_model dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   item_type    pending_items[$];
   reading_type expected_readings[$];
   item_type    item_on_bus;
   int          error_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_timer = 0;

   // predictor state and register copy
   cfg_type mdl_cfg;
   longint  prev_pos[3], prev_vel[3], held[3], last_out[3];
   longint  hist[3][HIST_DEPTH];
   int      hist_count, hist_head;

   function automatic longint sat_32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic void rotate_vec(input quat_t q, input vec3_t v, output vec3_t r);
      longint ww, d, cx, cy, cz;
      ww = q[0] * q[0] - q[1] * q[1] - q[2] * q[2] - q[3] * q[3];
      d  = q[1] * v[0] + q[2] * v[1] + q[3] * v[2];
      cx = q[2] * v[2] - q[3] * v[1];
      cy = q[3] * v[0] - q[1] * v[2];
      cz = q[1] * v[1] - q[2] * v[0];
      r[0] = (ww * v[0] + 2 * d * q[1] + 2 * q[0] * cx) >>> 28;
      r[1] = (ww * v[1] + 2 * d * q[2] + 2 * q[0] * cy) >>> 28;
      r[2] = (ww * v[2] + 2 * d * q[3] + 2 * q[0] * cz) >>> 28;
   endfunction

   function automatic longint times_rate(longint d, logic [31:0] inv);
      longint hi, lo;
      hi = longint'(inv[31:16]);
      lo = longint'(inv[15:0]);
      return sat_32(d * hi + ((d * lo) >>> 16));
   endfunction

   function automatic void unpack_axis(input logic [47:0] r, output vec3_t v);
      v[0] = longint'($signed(r[15:0]));
      v[1] = longint'($signed(r[31:16]));
      v[2] = longint'($signed(r[47:32]));
   endfunction

   function automatic void predict_reading(item_type it);
      quat_t       q;
      vec3_t       off, roff, p, vel, acc, ax, rax;
      longint      raw[3], sums[3], dot, mag;
      logic [47:0] axes[3];
      logic        over;
      int          len, idx;
      reading_type r;
      q[0] = longint'($signed(it.quat_w));
      q[1] = longint'($signed(it.quat_x));
      q[2] = longint'($signed(it.quat_y));
      q[3] = longint'($signed(it.quat_z));
      off[0] = longint'($signed(mdl_cfg.mount_offset[20:0]));
      off[1] = longint'($signed(mdl_cfg.mount_offset[41:21]));
      off[2] = longint'($signed(mdl_cfg.mount_offset[62:42]));
      rotate_vec(q, off, roff);
      p[0] = sat_32(longint'($signed(it.pos_x)) + roff[0]);
      p[1] = sat_32(longint'($signed(it.pos_y)) + roff[1]);
      p[2] = sat_32(longint'($signed(it.pos_z)) + roff[2]);
      over = 0;
      if (it.restart) begin
         for (int i = 0; i < 3; i++) begin
            prev_pos[i] = p[i];
            prev_vel[i] = 0;
            last_out[i] = 0;
         end
         hist_count = 0;
         hist_head = 0;
      end else if (mdl_cfg.inv_time_step != 0) begin
         for (int i = 0; i < 3; i++) begin
            vel[i] = times_rate(p[i] - prev_pos[i], mdl_cfg.inv_time_step);
            acc[i] = times_rate(vel[i] - prev_vel[i], mdl_cfg.inv_time_step);
         end
         acc[1] = sat_32(acc[1] + longint'($signed(mdl_cfg.gravity)));
         axes[0] = mdl_cfg.axis_one;
         axes[1] = mdl_cfg.axis_two;
         axes[2] = mdl_cfg.axis_three;
         for (int k = 0; k < 3; k++) begin
            unpack_axis(axes[k], ax);
            rotate_vec(q, ax, rax);
            dot = acc[0] * rax[0] + acc[1] * rax[1] + acc[2] * rax[2];
            raw[k] = (-dot) >>> 14;
            mag = raw[k] < 0 ? -raw[k] : raw[k];
            if (mag > longint'(mdl_cfg.max_reading)) over = 1;
         end
         len = int'(mdl_cfg.window_len);
         if (len < 1) len = 1;
         if (len > HIST_DEPTH) len = HIST_DEPTH;
         for (int k = 0; k < 3; k++) begin
            if (!over) held[k] = sat_32(raw[k]);
            hist[k][hist_head] = held[k];
         end
         hist_head = (hist_head + 1) % HIST_DEPTH;
         hist_count = hist_count + 1;
         if (hist_count > len) hist_count = len;
         for (int k = 0; k < 3; k++) begin
            sums[k] = 0;
            for (int i = 0; i < hist_count; i++) begin
               idx = (hist_head + HIST_DEPTH - 1 - i) % HIST_DEPTH;
               sums[k] += hist[k][idx];
            end
            last_out[k] = sat_32(sums[k] / longint'(len));
            prev_pos[k] = p[k];
            prev_vel[k] = vel[k];
         end
      end
      r.one = 32'(last_out[0]);
      r.two = 32'(last_out[1]);
      r.three = 32'(last_out[2]);
      r.frozen = over;
      expected_readings.push_back(r);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_reading(item_on_bus);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else if (pending_items.size() > 0) begin
               item_on_bus = pending_items.pop_front();
               req_restart <= item_on_bus.restart;
               req_pos_x <= item_on_bus.pos_x;
               req_pos_y <= item_on_bus.pos_y;
               req_pos_z <= item_on_bus.pos_z;
               req_quat_w <= item_on_bus.quat_w;
               req_quat_x <= item_on_bus.quat_x;
               req_quat_y <= item_on_bus.quat_y;
               req_quat_z <= item_on_bus.quat_z;
               req_valid <= 1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // response stall pattern and checker
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 2000);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= $urandom_range(0, 1);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= ((stall_timer / 97) % 2 == 1);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected transfer", 0, 0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_reading_one !== want.one)
                  report_mismatch("reading_one", rsp_reading_one, want.one);
               if (rsp_reading_two !== want.two)
                  report_mismatch("reading_two", rsp_reading_two, want.two);
               if (rsp_reading_three !== want.three)
                  report_mismatch("reading_three", rsp_reading_three, want.three);
               if (rsp_frozen !== want.frozen)
                  report_mismatch("frozen", rsp_frozen, want.frozen);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_INV_TIME_STEP: mdl_cfg.inv_time_step = value[31:0];
         REG_GRAVITY:       mdl_cfg.gravity = value[31:0];
         REG_MAX_READING:   mdl_cfg.max_reading = value[30:0];
         REG_WINDOW_LEN:    mdl_cfg.window_len = value[4:0];
         REG_MOUNT_OFFSET:  mdl_cfg.mount_offset = value[62:0];
         REG_AXIS_ONE:      mdl_cfg.axis_one = value[47:0];
         REG_AXIS_TWO:      mdl_cfg.axis_two = value[47:0];
         default:           mdl_cfg.axis_three = value[47:0];
      endcase
   endtask

   task automatic wait_drained();
      forever begin
         @(negedge clock);
         if (pending_items.size() == 0 && !req_valid && expected_readings.size() == 0) break;
      end
      repeat (250) @(posedge clock);
   endtask

   function automatic item_type make_item(logic rst, longint px, longint py, longint pz,
                                           logic [63:0] q);
      item_type it;
      it.restart = rst;
      it.pos_x = 32'(px);
      it.pos_y = 32'(py);
      it.pos_z = 32'(pz);
      {it.quat_w, it.quat_x, it.quat_y, it.quat_z} = q;
      return it;
   endfunction

   function automatic logic [63:0] pick_quat();
      logic [15:0] c[4];
      int sel;
      sel = $urandom_range(0, 9);
      c = '{16'd0, 16'd0, 16'd0, 16'd0};
      case (sel)
         0, 1: c[$urandom_range(0, 3)] = 16'd16384;
         2, 3: begin
            c[0] = 16'd11585;
            c[$urandom_range(1, 3)] = 16'd11585;
         end
         4, 5: c = '{16'd8192, 16'd8192, 16'd8192, 16'd8192};
         6: c = '{16'd15137, 16'd6270, 16'd0, 16'd0};
         default: for (int i = 0; i < 4; i++) c[i] = 16'($urandom);
      endcase
      if (sel < 7) begin
         for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 1) == 1) c[i] = -c[i];
      end
      return {c[0], c[1], c[2], c[3]};
   endfunction

   // restart followed by a smooth trajectory, with some noise items mixed in
   task automatic queue_random_items(int count);
      longint pos[3], vel[3];
      int n, seg;
      logic [63:0] q;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_items.push_back(make_item($urandom_range(0, 1), int'($urandom),
               int'($urandom), int'($urandom), {$urandom, $urandom}));
            n++;
            continue;
         end
         for (int i = 0; i < 3; i++) begin
            pos[i] = $signed(32'($urandom_range(0, 200000))) - 100000;
            vel[i] = $signed(32'($urandom_range(0, 400))) - 200;
         end
         q = pick_quat();
         pending_items.push_back(make_item(1, pos[0], pos[1], pos[2], q));
         n++;
         seg = $urandom_range(3, 40);
         for (int s = 0; s < seg && n < count; s++) begin
            for (int i = 0; i < 3; i++) begin
               vel[i] += longint'($urandom_range(0, 80)) - 40;
               if ($urandom_range(0, 29) == 0) vel[i] += longint'($urandom_range(0, 4000)) - 2000;
               pos[i] = sat_32(pos[i] + vel[i]);
            end
            if ($urandom_range(0, 4) == 0) q = pick_quat();
            pending_items.push_back(make_item(0, pos[0], pos[1], pos[2], q));
            n++;
         end
      end
   endtask

   initial begin
      longint ext[4];
      mdl_cfg.inv_time_step = RST_INV_TIME_STEP;
      mdl_cfg.gravity = 0;
      mdl_cfg.max_reading = RST_MAX_READING;
      mdl_cfg.window_len = RST_WINDOW_LEN;
      mdl_cfg.mount_offset = 0;
      mdl_cfg.axis_one = RST_AXIS_ONE;
      mdl_cfg.axis_two = RST_AXIS_TWO;
      mdl_cfg.axis_three = RST_AXIS_THREE;
      for (int i = 0; i < 3; i++) begin
         prev_pos[i] = 0;
         prev_vel[i] = 0;
         held[i] = 0;
         last_out[i] = 0;
      end
      hist_count = 0;
      hist_head = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: reset settings, field extremes, restart and freeze
      ext = '{64'sd2147483647, -64'sd2147483648, 0, 64'sd65536};
      pending_items.push_back(make_item(0, 100, -200, 300, {16'd16384, 48'd0}));
      pending_items.push_back(make_item(1, 0, 0, 0, {16'd16384, 48'd0}));
      pending_items.push_back(make_item(0, 10, 20, -30, {16'd16384, 48'd0}));
      pending_items.push_back(make_item(0, 40, 80, -120, {16'd16384, 48'd0}));
      for (int i = 0; i < 4; i++)
         pending_items.push_back(make_item(0, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
            {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}));
      pending_items.push_back(make_item(1, ext[0], ext[1], ext[0], {16'h7fff, 48'd0}));
      pending_items.push_back(make_item(0, ext[1], ext[0], ext[1], {16'hffff, 16'hffff,
         16'hffff, 16'hffff}));
      pending_items.push_back(make_item(0, 0, 0, 0, 64'd0));
      pending_items.push_back(make_item(1, 5, 5, 5, {16'd11585, 16'd11585, 32'd0}));
      pending_items.push_back(make_item(0, 7, 3, 9, {16'd11585, 16'd11585, 32'd0}));
      wait_drained();
      write_reg(REG_INV_TIME_STEP, 0);
      pending_items.push_back(make_item(0, 999, 999, 999, {16'd16384, 48'd0}));
      pending_items.push_back(make_item(1, 55, 66, 77, {16'd16384, 48'd0}));
      pending_items.push_back(make_item(0, 999, 999, 999, {16'd16384, 48'd0}));
      wait_drained();
      write_reg(REG_INV_TIME_STEP, RST_INV_TIME_STEP);
      queue_random_items(80);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_INV_TIME_STEP, 64'hffff_ffff);
               write_reg(REG_GRAVITY, 64'h7fff_ffff);
               write_reg(REG_MAX_READING, 64'h7fff_ffff);
               write_reg(REG_WINDOW_LEN, 16);
            end
            1: begin
               write_reg(REG_INV_TIME_STEP, 64'd65536);
               write_reg(REG_GRAVITY, 64'h8000_0000);
               write_reg(REG_MAX_READING, 0);
               write_reg(REG_WINDOW_LEN, 0);
               write_reg(REG_MOUNT_OFFSET, 64'h7fff_ffff_ffff_ffff);
            end
            2: begin
               write_reg(REG_INV_TIME_STEP, 64'd6553600);
               write_reg(REG_GRAVITY, 64'hfff4_3c4a);
               write_reg(REG_MAX_READING, 64'd771490);
               write_reg(REG_WINDOW_LEN, 31);
               write_reg(REG_MOUNT_OFFSET, {1'b0, 21'h100000, 21'h100000, 21'h100000});
               write_reg(REG_AXIS_ONE, 48'hffff_ffff_ffff);
               write_reg(REG_AXIS_TWO, 48'h8000_8000_8000);
               write_reg(REG_AXIS_THREE, 48'h7fff_7fff_7fff);
            end
            3: begin
               write_reg(REG_AXIS_ONE, 48'd0);
               write_reg(REG_AXIS_TWO, RST_AXIS_TWO);
               write_reg(REG_AXIS_THREE, RST_AXIS_THREE);
               write_reg(REG_WINDOW_LEN, 4);
               write_reg(REG_MOUNT_OFFSET, 64'd0);
            end
            default: begin
               write_reg(REG_INV_TIME_STEP, $urandom_range(0, 7) == 0 ? 64'd0 :
                  64'($urandom_range(1, 200)) << 16);
               write_reg(REG_GRAVITY, 64'($signed(32'($urandom_range(0, 1600000)) - 800000)));
               write_reg(REG_MAX_READING, 64'($urandom_range(100000, 4000000)));
               write_reg(REG_WINDOW_LEN, 64'($urandom_range(1, 16)));
               write_reg(REG_MOUNT_OFFSET, {1'b0, $urandom, $urandom});
               write_reg(REG_AXIS_ONE, {$urandom, $urandom});
               write_reg(REG_AXIS_TWO, {$urandom, $urandom});
               write_reg(REG_AXIS_THREE, {$urandom, $urandom});
            end
         endcase
         queue_random_items(90);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/asm_pkg.sv
hw/rtl/asm_front.sv
hw/rtl/asm_mac.sv
hw/rtl/asm_back.sv
hw/rtl/accel_sensor_model.sv
dv/accel_sensor_model_tb.sv
